/* sv/boll_pkg.sv */
// shared types, constants and command/status structs for the ordered list engine
package boll_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int COUNT_W  = 7;

	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;

	// command kinds
	typedef enum logic [2:0] {
		KIND_FRONT  = 3'd0,
		KIND_BEFORE = 3'd1,
		KIND_APPEND = 3'd2,
		KIND_DELETE = 3'd3,
		KIND_SEARCH = 3'd4
	} kind_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// where an insert lands
	typedef enum logic [1:0] {
		POS_HEAD = 2'd0,
		POS_HIT  = 2'd1,
		POS_TAIL = 2'd2
	} pos_sel_t;

	// controller to datapath
	typedef struct packed {
		logic     load;
		logic     scan;
		logic     prep_up;
		pos_sel_t pos_sel;
		logic     prep_dn;
		logic     shift_up;
		logic     shift_dn;
		logic     ins_write;
		logic     dec_occ;
		logic     finish;
		status_t  status;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
		logic hit;
		logic empty;
		logic full;
		logic up_last;
		logic dn_last;
		logic out_busy;
	} dp_stat_t;

endpackage

/* sv/bounded_ordered_list_engine_top.sv */
// top level of the bounded ordered list engine
//
// Keeps an ordered list of up to 64 signed 32-bit entries, head at position 0.
// Input channel (in_valid/in_stall) carries kind, key and value; one output
// transaction (out_valid/out_stall) carries status, found and entry_count.
// A transaction is taken at a clock edge where valid is high and stall is low.
// Every command first walks the list one entry per cycle until the first entry
// equal to key or the end of the list, through a single-ported read of the
// entry memory. Inserts then move the entries behind the insert point up one
// entry per cycle, and deletes move them down the same way. One command is in
// flight at a time: in_stall is high until the result is loaded into the
// output register. A result held by out_stall keeps its register; the next
// command is accepted and worked on meanwhile, and waits only at its own
// result. Reset (arst_n low) empties the list and drops any pending result;
// no clearing pass is needed.
module bounded_ordered_list_engine_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [2:0]                   kind,
	input  logic signed [31:0]           key,
	input  logic signed [31:0]           value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   status,
	output logic                         found,
	output logic [boll_pkg::COUNT_W-1:0] entry_count
);
	import boll_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     busy;

	// input is held off while a command is in progress
	assign in_stall = busy;

	boll_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.busy     (busy),
		.cmd      (cmd),
		.stat     (stat)
	);

	boll_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.key         (key),
		.value       (value),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.status      (status),
		.found       (found),
		.entry_count (entry_count)
	);

endmodule

/* sv/boll_dp.sv */
// datapath: entry memory, walk counter, occupancy and result register
module boll_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  boll_pkg::dp_cmd_t                    cmd,
	output boll_pkg::dp_stat_t                   stat,
	input  logic signed [31:0]                   key,
	input  logic signed [31:0]                   value,
	input  logic                                 out_stall,
	output logic                                 out_valid,
	output logic [1:0]                           status,
	output logic                                 found,
	output logic [boll_pkg::COUNT_W-1:0]         entry_count
);
	import boll_pkg::*;

	logic [31:0] mem [CAPACITY];

	logic signed [31:0] key_q;
	logic signed [31:0] value_q;
	cnt_t               occ_q;
	cnt_t               cur_q;
	cnt_t               p_q;
	cnt_t               pos_q;
	logic               found_q;
	logic               pend_s1;
	addr_t              tag_s1;
	logic [31:0]        rd_data_s1;
	logic               out_valid_q;
	logic [1:0]         status_q;
	logic               found_out_q;
	logic [COUNT_W-1:0] count_out_q;

	logic  hit_now;
	logic  scan_end;
	logic  rd_en;
	addr_t rd_addr;
	addr_t tag_d;
	logic  mem_we;
	addr_t mem_waddr;
	logic [31:0] mem_wdata;
	cnt_t  cur_d;
	cnt_t  up_p;

	// scan compare on the registered read data
	assign hit_now  = pend_s1 && (rd_data_s1 == key_q);
	assign scan_end = (cur_q == occ_q);

	assign stat.scan_done = hit_now || scan_end;
	assign stat.hit       = found_q;
	assign stat.empty     = (occ_q == '0);
	assign stat.full      = (occ_q >= cnt_t'(CAPACITY));
	assign stat.up_last   = (cur_q == p_q);
	assign stat.dn_last   = !(cur_q < occ_q);
	assign stat.out_busy  = out_valid_q && out_stall;

	// insert position
	always_comb begin
		unique case (cmd.pos_sel)
			POS_HEAD: up_p = '0;
			POS_HIT:  up_p = pos_q;
			POS_TAIL: up_p = occ_q;
			default:  up_p = occ_q;
		endcase
	end

	// read port and walk counter
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cur_q[ADDR_W-1:0];
		tag_d   = cur_q[ADDR_W-1:0];
		cur_d   = cur_q;
		if (cmd.scan && !(hit_now || scan_end)) begin
			rd_en = 1'b1;
			cur_d = cur_q + 1'b1;
		end else if (cmd.shift_up && (cur_q != p_q)) begin
			rd_en   = 1'b1;
			rd_addr = addr_t'(cur_q - 1'b1);
			cur_d   = cur_q - 1'b1;
		end else if (cmd.shift_dn && (cur_q < occ_q)) begin
			rd_en = 1'b1;
			tag_d = addr_t'(cur_q - 1'b1);
			cur_d = cur_q + 1'b1;
		end
	end

	// write port: shifted entry or new value
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = tag_s1;
		mem_wdata = rd_data_s1;
		if ((cmd.shift_up || cmd.shift_dn) && pend_s1) begin
			mem_we = 1'b1;
		end else if (cmd.ins_write) begin
			mem_we    = 1'b1;
			mem_waddr = p_q[ADDR_W-1:0];
			mem_wdata = value_q;
		end
	end

	// entry memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_s1 <= rd_en && !(cmd.load || cmd.prep_up || cmd.prep_dn);
			if (cmd.ins_write) begin
				occ_q <= occ_q + 1'b1;
			end else if (cmd.dec_occ) begin
				occ_q <= occ_q - 1'b1;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		tag_s1 <= tag_d;
		if (cmd.load) begin
			cur_q <= '0;
		end else if (cmd.prep_up) begin
			cur_q <= occ_q;
		end else if (cmd.prep_dn) begin
			cur_q <= pos_q + 1'b1;
		end else begin
			cur_q <= cur_d;
		end
		if (cmd.load) begin
			key_q   <= key;
			value_q <= value;
			found_q <= 1'b0;
		end
		if (cmd.scan && (hit_now || scan_end)) begin
			found_q <= hit_now;
			pos_q   <= hit_now ? cnt_t'(tag_s1) : occ_q;
		end
		if (cmd.prep_up) begin
			p_q   <= up_p;
		end
		if (cmd.finish) begin
			status_q    <= cmd.status;
			found_out_q <= found_q;
			count_out_q <= COUNT_W'(occ_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found       = found_out_q;
	assign entry_count = count_out_q;

endmodule

/* sv/boll_ctrl.sv */
// controller: sequences scan, shift and write steps of one command
module boll_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [2:0]         kind,
	output logic               busy,
	output boll_pkg::dp_cmd_t  cmd,
	input  boll_pkg::dp_stat_t stat
);
	import boll_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_SCAN   = 7'b0000010,
		S_DECIDE = 7'b0000100,
		S_SHUP   = 7'b0001000,
		S_SHDN   = 7'b0010000,
		S_WRITE  = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t      state_q, state_d;
	logic [2:0]  kind_q;
	status_t     status_q, status_d;

	assign busy = (state_q != S_IDLE);

	// next state and datapath commands
	always_comb begin
		state_d  = state_q;
		status_d = status_q;
		cmd      = '0;
		cmd.pos_sel = POS_HEAD;
		cmd.status  = status_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_done) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				status_d = ST_OK;
				state_d  = S_DONE;
				unique case (kind_q)
					KIND_FRONT: begin
						if (stat.full) begin
							status_d = ST_FULL;
						end else begin
							cmd.prep_up = 1'b1;
							cmd.pos_sel = POS_HEAD;
							state_d     = S_SHUP;
						end
					end
					KIND_BEFORE: begin
						if (stat.full) begin
							status_d = ST_FULL;
						end else if (stat.empty) begin
							cmd.prep_up = 1'b1;
							cmd.pos_sel = POS_HEAD;
							state_d     = S_SHUP;
						end else if (!stat.hit) begin
							status_d = ST_NOT_FOUND;
						end else begin
							cmd.prep_up = 1'b1;
							cmd.pos_sel = POS_HIT;
							state_d     = S_SHUP;
						end
					end
					KIND_APPEND: begin
						if (stat.full) begin
							status_d = ST_FULL;
						end else begin
							cmd.prep_up = 1'b1;
							cmd.pos_sel = POS_TAIL;
							state_d     = S_SHUP;
						end
					end
					KIND_DELETE: begin
						if (stat.empty) begin
							status_d = ST_EMPTY;
						end else if (!stat.hit) begin
							status_d = ST_NOT_FOUND;
						end else begin
							cmd.prep_dn = 1'b1;
							state_d     = S_SHDN;
						end
					end
					KIND_SEARCH: begin
						status_d = stat.hit ? ST_OK : ST_NOT_FOUND;
					end
					default: begin
						status_d = ST_OK;
					end
				endcase
			end
			S_SHUP: begin
				cmd.shift_up = 1'b1;
				if (stat.up_last) begin
					state_d = S_WRITE;
				end
			end
			S_SHDN: begin
				cmd.shift_dn = 1'b1;
				if (stat.dn_last) begin
					cmd.dec_occ = 1'b1;
					state_d     = S_DONE;
				end
			end
			S_WRITE: begin
				cmd.ins_write = 1'b1;
				state_d       = S_DONE;
			end
			S_DONE: begin
				if (!stat.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// command kind and decided status
	always_ff @(posedge clk) begin
		status_q <= status_d;
		if (cmd.load) begin
			kind_q <= kind;
		end
	end

endmodule
